@@ design/spd_pkg.sv @@
// Shared types, constants and helper functions for the serial packet deframer.
// Used by spd_parser, spd_sequencer and serial_packet_deframer_with_ack_core.
// No dependencies.
package spd_pkg;

	// Packet framing constants.
	localparam int MAX_CONTENT = 64;
	localparam int CNT_W       = $clog2(MAX_CONTENT + 1);
	localparam int ACK_LEN     = 11;
	localparam int SUB_W       = $clog2(ACK_LEN);

	localparam logic [7:0] CH_START = 8'h24;   // '$'
	localparam logic [7:0] CH_STAR  = 8'h2A;   // '*'
	localparam logic [7:0] CH_FILL  = 8'hFF;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] ACK_ASK  = 8'h01;

	// Index of the final acknowledge byte.
	localparam logic [SUB_W-1:0] ACK_LAST = SUB_W'(ACK_LEN - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CONTENT - 1);

	// Result kinds as carried on the master-side tuser.
	typedef enum logic [1:0] {
		KIND_CONTENT = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_ACK     = 2'd2
	} kind_t;

	// Receive phases.
	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_CONTENT = 2'd2
	} phase_t;

	// Parser status handed to the sequencer.
	typedef struct packed {
		phase_t     phase;
		logic       ack_pending;
		logic       at_end;
		logic [7:0] id;
		logic [7:0] ptype;
		logic [7:0] subtype;
		logic [7:0] ack_req;
	} info_t;

	// Byte of the acknowledge frame at a given position.
	function automatic logic [7:0] ack_byte(input logic [SUB_W-1:0] idx, input logic [7:0] id);
		logic [7:0] res;
		case (idx)
			SUB_W'(0):  res = CH_START;
			SUB_W'(1):  res = CH_STAR;
			SUB_W'(2):  res = id;
			SUB_W'(3):  res = CH_FILL;
			SUB_W'(4):  res = CH_FILL;
			SUB_W'(5):  res = CH_FILL;
			SUB_W'(6):  res = CH_A;
			SUB_W'(7):  res = CH_C;
			SUB_W'(8):  res = CH_K;
			SUB_W'(9):  res = CH_STAR;
			SUB_W'(10): res = CH_START;
			default:    res = 8'h00;
		endcase
		return res;
	endfunction

endpackage

@@ design/serial_packet_deframer_with_ack_core.sv @@
// Top level of the serial packet deframer with acknowledge.
// Depends on spd_pkg, spd_parser and spd_sequencer.
//
// Usage: received bytes enter on the slave stream (s_tdata, one byte per
// request). Results leave on the master stream: m_tuser gives the kind
// (content byte, packet complete, acknowledge byte), m_tdata carries the data
// byte and the four captured header bytes, and m_tlast marks the last result
// caused by one input byte. Marker and header bytes produce no results.
// A byte sits in an input register, then its results are produced one per
// cycle into the output register while the receiver keeps m_tready high.
// Content bytes sustain one byte per cycle while m_tready stays high; a packet's
// final byte gives two results (content and complete), and the byte after an
// acknowledged packet gives the eleven results of the acknowledge burst.
// Bytes that cause no result are consumed even while the output is stalled.
// Reset clears the hunt state, the header bytes and the valid flags of both stream registers.
// When the receiver stalls, the output register holds its result, the input
// register fills, and s_tready then drops until results move again.
module serial_packet_deframer_with_ack_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // data_byte, packet_id, packet_type, packet_subtype, ack_request
	output logic [1:0]  m_tuser,    // kind
	output logic        m_tlast
);
	import spd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       consume;
	info_t      info;

	assign s_tready = !valid_s1 || consume;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	spd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (byte_s1),
		.consume (consume),
		.info    (info)
	);

	spd_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.info     (info),
		.consume  (consume),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ design/spd_parser.sv @@
// Frame parser: marker hunt, header capture, content counting and ack flag.
// Depends on spd_pkg. State advances once per consumed byte.
module spd_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     rx_byte,
	input  logic           consume,
	output spd_pkg::info_t info
);
	import spd_pkg::*;

	phase_t            phase_q;
	logic              marker_q;
	logic [1:0]        hdr_cnt_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [3:0][7:0]   hdr_q;
	logic              ack_pend_q;
	logic              at_end;

	// A content byte ends the packet on zero or when the limit is reached.
	assign at_end = (rx_byte == 8'h00) || (cnt_q == CNT_LAST);

	assign info.phase       = phase_q;
	assign info.ack_pending = ack_pend_q;
	assign info.at_end      = at_end;
	assign info.id          = hdr_q[0];
	assign info.ptype       = hdr_q[1];
	assign info.subtype     = hdr_q[2];
	assign info.ack_req     = hdr_q[3];

	// State update on each consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			marker_q   <= 1'b0;
			hdr_cnt_q  <= 2'd0;
			cnt_q      <= '0;
			hdr_q      <= '0;
			ack_pend_q <= 1'b0;
		end else if (consume) begin
			ack_pend_q <= 1'b0;
			case (phase_q)
				PH_HEADER: begin
					hdr_q[hdr_cnt_q] <= rx_byte;
					hdr_cnt_q        <= hdr_cnt_q + 2'd1;
					if (hdr_cnt_q == 2'd3) begin
						phase_q <= PH_CONTENT;
						cnt_q   <= '0;
					end
				end
				PH_CONTENT: begin
					if (at_end) begin
						phase_q    <= PH_HUNT;
						marker_q   <= 1'b0;
						cnt_q      <= '0;
						ack_pend_q <= (hdr_q[3] == ACK_ASK);
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					phase_q <= PH_HUNT;
					if (rx_byte == CH_START) begin
						marker_q <= 1'b1;
					end else if (marker_q && rx_byte == CH_STAR) begin
						marker_q  <= 1'b0;
						phase_q   <= PH_HEADER;
						hdr_cnt_q <= 2'd0;
					end else begin
						marker_q <= 1'b0;
					end
				end
			endcase
		end
	end

endmodule

@@ design/spd_sequencer.sv @@
// Result sequencer: walks the results of one byte and fills the output register.
// Depends on spd_pkg; takes parser status from spd_parser.
module spd_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  logic [7:0]     byte_s1,
	input  spd_pkg::info_t info,
	output logic           consume,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [39:0]    m_tdata,   // data_byte, packet_id, packet_type, packet_subtype, ack_request
	output logic [1:0]     m_tuser,   // kind
	output logic           m_tlast
);
	import spd_pkg::*;

	logic [SUB_W-1:0] sub_q;
	logic             valid_q;
	logic [39:0]      data_q;
	kind_t            kind_q;
	logic             last_q;

	logic             emit;
	logic             final_res;
	kind_t            kind_n;
	logic [7:0]       byte_n;
	logic             last_n;
	logic             out_free;
	logic             step;

	// Pick the result for the current position within this byte's list.
	always_comb begin
		emit      = 1'b0;
		final_res = 1'b1;
		kind_n    = KIND_CONTENT;
		byte_n    = 8'h00;
		last_n    = 1'b0;
		if (info.ack_pending) begin
			emit      = 1'b1;
			kind_n    = KIND_ACK;
			byte_n    = ack_byte(sub_q, info.id);
			last_n    = (sub_q == ACK_LAST);
			final_res = (sub_q == ACK_LAST);
		end else if (info.phase == PH_CONTENT) begin
			emit = 1'b1;
			if (sub_q == '0) begin
				kind_n    = KIND_CONTENT;
				byte_n    = byte_s1;
				last_n    = !info.at_end;
				final_res = !info.at_end;
			end else begin
				kind_n    = KIND_DONE;
				byte_n    = 8'h00;
				last_n    = 1'b1;
				final_res = 1'b1;
			end
		end
	end

	assign out_free = !valid_q || m_tready;
	assign step     = valid_s1 && (!emit || out_free);
	assign consume  = step && final_res;

	// Position counter within the current byte's results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
		end else if (step) begin
			sub_q <= final_res ? '0 : sub_q + SUB_W'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && emit) begin
			data_q <= {info.ack_req, info.subtype, info.ptype, info.id, byte_n};
			kind_q <= kind_n;
			last_q <= last_n;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule
